// ----- design/lgrb_pkg.sv -----
package lgrb_pkg;

  localparam int GRAPH_WIDTH_DEF  = 48;
  localparam int GRAPH_HEIGHT_DEF = 48;

  localparam int SAMPLE_W = 32;
  localparam int PING_W   = 30;
  localparam int REG_W    = 9;
  localparam int DROP_W   = 8;
  localparam int COLOR_W  = 8;
  localparam int ADDR_W   = 3;

  localparam int FLAG_CRIT_BIT = 31;
  localparam int FLAG_WARN_BIT = 30;

  localparam logic [PING_W-1:0]  PING_MAX      = '1;
  localparam logic [REG_W-1:0]   GRAPH_MIN_RST = 9'd0;
  localparam logic [REG_W-1:0]   GRAPH_MAX_RST = 9'd200;
  localparam logic [COLOR_W-1:0] COLOR_BASE    = 8'hD5;
  localparam logic [COLOR_W-1:0] COLOR_WARN    = 8'hDC;
  localparam logic [COLOR_W-1:0] COLOR_CRIT    = 8'hF2;

  // register index taken from paddr[2]
  localparam logic REG_GRAPH_MIN = 1'b0;
  localparam logic REG_GRAPH_MAX = 1'b1;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_DRAW  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_SETUP,
    ST_RD,
    ST_MUL,
    ST_CHK,
    ST_DIV
  } state_e;

  typedef struct packed {
    logic push;
    logic clear;
    logic rd_en;
  } ring_ctl_t;

endpackage

// ----- design/lgrb_ring.sv -----
module lgrb_ring #(
  parameter int GRAPH_WIDTH = lgrb_pkg::GRAPH_WIDTH_DEF,
  parameter int PTR_W       = $clog2(GRAPH_WIDTH),
  parameter int CNT_W       = $clog2(GRAPH_WIDTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lgrb_pkg::ring_ctl_t           ctl_i,
  input  logic [lgrb_pkg::SAMPLE_W-1:0] push_data_i,
  input  logic [PTR_W-1:0]              rd_idx_i,
  output logic [lgrb_pkg::SAMPLE_W-1:0] rd_data_o,
  output logic [CNT_W-1:0]              fill_o
);

  logic [lgrb_pkg::SAMPLE_W-1:0] mem [GRAPH_WIDTH];
  logic [PTR_W-1:0] wp_q, wp_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [PTR_W:0]   slot_sum;
  logic [PTR_W-1:0] rd_slot;

  // newest first: slot = (wp - 1 - idx) mod width
  always_comb begin
    slot_sum = {1'b0, wp_q} + (PTR_W + 1)'(GRAPH_WIDTH - 1) - {1'b0, rd_idx_i};
    if (slot_sum >= (PTR_W + 1)'(GRAPH_WIDTH)) begin
      rd_slot = PTR_W'(slot_sum - (PTR_W + 1)'(GRAPH_WIDTH));
    end else begin
      rd_slot = PTR_W'(slot_sum);
    end
  end

  always_comb begin
    wp_d   = wp_q;
    fill_d = fill_q;
    if (ctl_i.clear) begin
      wp_d   = '0;
      fill_d = '0;
    end else if (ctl_i.push) begin
      wp_d = (wp_q == PTR_W'(GRAPH_WIDTH - 1)) ? '0 : wp_q + PTR_W'(1);
      if (fill_q != CNT_W'(GRAPH_WIDTH)) begin
        fill_d = fill_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
    end else begin
      wp_q   <= wp_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push && !ctl_i.clear) begin
      mem[wp_q] <= push_data_i;
    end
    if (ctl_i.rd_en) begin
      rd_data_o <= mem[rd_slot];
    end
  end

  assign fill_o = fill_q;

endmodule

// ----- design/lgrb_div.sv -----
module lgrb_div #(
  parameter int NUM_W = 36,
  parameter int DEN_W = 9,
  parameter int QUO_W = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [QUO_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic             active_q, active_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] dsh_q, dsh_d;
  logic [QUO_W-1:0] quo_q, quo_d;
  logic             ge;

  // restoring division, one quotient bit per cycle, msb first
  assign ge = rem_q >= dsh_q;

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    dsh_d    = dsh_q;
    quo_d    = quo_q;
    if (start_i) begin
      active_d = 1'b1;
      cnt_d    = CNT_W'(QUO_W);
      rem_d    = num_i;
      dsh_d    = NUM_W'(den_i) << (QUO_W - 1);
      quo_d    = '0;
    end else if (active_q) begin
      rem_d = ge ? rem_q - dsh_q : rem_q;
      dsh_d = dsh_q >> 1;
      quo_d = {quo_q[QUO_W-2:0], ge};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsh_q <= dsh_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- design/latency_graph_ring_buffer_top.sv -----
// latency graph ring buffer
// command channel: an item is taken at a clock edge with start high and busy
// low. op add stores a sample (one critical copy per dropped packet, then the
// ping itself) at one ring write per cycle. op clear empties the ring. op
// draw, if clamped graph_max exceeds clamped graph_min and the ring holds
// samples, walks them newest first and emits one beat per sample on column_o,
// bar_height_o, palette_color_o and last_o, marked by out_valid_o for a single
// cycle. each sample passes a ring read, a multiply and a check step and,
// unless the bar is clamped, the divider. busy stays high for the whole add
// or draw op. the user must write graph_min and graph_max over the apb port
// only while busy is low; the block does not enforce this. reset empties the
// ring and loads graph_min 0 and graph_max 200. the receiver cannot stall:
// every beat is taken in the cycle it is shown.
module latency_graph_ring_buffer_top #(
  parameter int GRAPH_WIDTH  = lgrb_pkg::GRAPH_WIDTH_DEF,
  parameter int GRAPH_HEIGHT = lgrb_pkg::GRAPH_HEIGHT_DEF,
  parameter int COL_W        = $clog2(GRAPH_WIDTH),
  parameter int HGT_W        = $clog2(GRAPH_HEIGHT + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lgrb_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    op_i,
  input  logic                          command_valid_i,
  input  logic [31:0]                   time_sent_i,
  input  logic [31:0]                   time_received_i,
  input  logic [lgrb_pkg::DROP_W-1:0]   dropped_count_i,
  input  logic                          suppressed_i,
  output logic                          out_valid_o,
  output logic [COL_W-1:0]              column_o,
  output logic [HGT_W-1:0]              bar_height_o,
  output logic [lgrb_pkg::COLOR_W-1:0]  palette_color_o,
  output logic                          last_o
);

  localparam int PTR_W   = COL_W;
  localparam int CNT_W   = $clog2(GRAPH_WIDTH + 1);
  localparam int LIM_TOP = GRAPH_HEIGHT * 10;
  localparam int LIM_W   = ($clog2(LIM_TOP + 1) > lgrb_pkg::REG_W) ?
                           $clog2(LIM_TOP + 1) : lgrb_pkg::REG_W;
  localparam int NUM_W   = lgrb_pkg::PING_W + HGT_W;
  localparam int HR_W    = LIM_W + HGT_W;
  localparam int PW      = lgrb_pkg::PING_W;
  localparam int SW      = lgrb_pkg::SAMPLE_W;

  lgrb_pkg::state_e state_q, state_d;
  lgrb_pkg::ring_ctl_t ring_ctl;

  logic [lgrb_pkg::REG_W-1:0] graph_min_q, graph_min_d, graph_max_q, graph_max_d;
  logic [PW-1:0]              ping_q, ping_d;
  logic                       supp_q, supp_d;
  logic [lgrb_pkg::DROP_W-1:0] drops_q, drops_d;
  logic [LIM_W-1:0]           lo_q, lo_d, range_q, range_d;
  logic [HR_W-1:0]            hrange_q, hrange_d;
  logic [PTR_W-1:0]           idx_q, idx_d;
  logic                       neg_q, neg_d;
  logic [NUM_W-1:0]           num_q, num_d;
  logic [lgrb_pkg::COLOR_W-1:0] color_q, color_d;
  logic                       out_valid_q, out_valid_d;
  logic [COL_W-1:0]           column_q, column_d;
  logic [HGT_W-1:0]           height_q, height_d;
  logic [lgrb_pkg::COLOR_W-1:0] pcolor_q, pcolor_d;
  logic                       last_q, last_d;

  logic              accept, cfg_wr;
  logic [SW-1:0]     push_data, rd_data;
  logic [CNT_W-1:0]  fill;
  logic [LIM_W-1:0]  min_ext, max_ext, lo_c, hi_c;
  logic [31:0]       diff_c;
  logic [PW-1:0]     ping_c, ping_s, diff_s;
  logic              add_ok, idx_last;
  logic              div_start, div_done;
  logic [HGT_W-1:0]  div_quo;
  logic              emit;
  logic [HGT_W-1:0]  emit_h;

  assign accept = start && !busy;
  assign busy   = state_q != lgrb_pkg::ST_IDLE;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == lgrb_pkg::REG_GRAPH_MAX) ? 32'(graph_max_q) : 32'(graph_min_q);

  always_comb begin
    graph_min_d = graph_min_q;
    graph_max_d = graph_max_q;
    if (cfg_wr) begin
      if (paddr[2] == lgrb_pkg::REG_GRAPH_MIN) begin
        graph_min_d = pwdata[lgrb_pkg::REG_W-1:0];
      end else begin
        graph_max_d = pwdata[lgrb_pkg::REG_W-1:0];
      end
    end
  end

  // limits clamped to height * 10
  always_comb begin
    min_ext = LIM_W'(graph_min_q);
    max_ext = LIM_W'(graph_max_q);
    lo_c    = (min_ext > LIM_W'(LIM_TOP)) ? LIM_W'(LIM_TOP) : min_ext;
    hi_c    = (max_ext > LIM_W'(LIM_TOP)) ? LIM_W'(LIM_TOP) : max_ext;
  end

  always_comb begin
    diff_c = time_received_i - time_sent_i;
    ping_c = (diff_c[31:30] != 2'b00) ? lgrb_pkg::PING_MAX : diff_c[PW-1:0];
    add_ok = command_valid_i && (time_received_i >= time_sent_i);
    ping_s = rd_data[PW-1:0];
    diff_s = ping_s - PW'(lo_q);
    idx_last = (CNT_W'(idx_q) + CNT_W'(1)) == fill;
  end

  always_comb begin
    state_d     = state_q;
    ping_d      = ping_q;
    supp_d      = supp_q;
    drops_d     = drops_q;
    lo_d        = lo_q;
    range_d     = range_q;
    hrange_d    = hrange_q;
    idx_d       = idx_q;
    neg_d       = neg_q;
    num_d       = num_q;
    color_d     = color_q;
    ring_ctl    = '0;
    push_data   = '0;
    div_start   = 1'b0;
    emit        = 1'b0;
    emit_h      = '0;
    case (state_q)
      lgrb_pkg::ST_IDLE: begin
        if (accept) begin
          case (op_i)
            lgrb_pkg::OP_ADD: begin
              if (add_ok) begin
                ping_d  = ping_c;
                supp_d  = suppressed_i;
                drops_d = dropped_count_i;
                state_d = lgrb_pkg::ST_ADD;
              end
            end
            lgrb_pkg::OP_DRAW: begin
              if (hi_c > lo_c && fill != '0) begin
                lo_d    = lo_c;
                range_d = hi_c - lo_c;
                state_d = lgrb_pkg::ST_SETUP;
              end
            end
            lgrb_pkg::OP_CLEAR: begin
              ring_ctl.clear = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      lgrb_pkg::ST_ADD: begin
        ring_ctl.push = 1'b1;
        if (drops_q != '0) begin
          push_data = {1'b1, 1'b0, ping_q};
          drops_d   = drops_q - lgrb_pkg::DROP_W'(1);
        end else begin
          push_data = {1'b0, supp_q, ping_q};
          state_d   = lgrb_pkg::ST_IDLE;
        end
      end
      lgrb_pkg::ST_SETUP: begin
        hrange_d = HR_W'(range_q) * HR_W'(GRAPH_HEIGHT);
        idx_d    = '0;
        state_d  = lgrb_pkg::ST_RD;
      end
      lgrb_pkg::ST_RD: begin
        ring_ctl.rd_en = 1'b1;
        state_d        = lgrb_pkg::ST_MUL;
      end
      lgrb_pkg::ST_MUL: begin
        neg_d = ping_s < PW'(lo_q);
        num_d = NUM_W'(diff_s) * NUM_W'(GRAPH_HEIGHT);
        if (rd_data[lgrb_pkg::FLAG_CRIT_BIT]) begin
          color_d = lgrb_pkg::COLOR_CRIT;
        end else if (rd_data[lgrb_pkg::FLAG_WARN_BIT]) begin
          color_d = lgrb_pkg::COLOR_WARN;
        end else begin
          color_d = lgrb_pkg::COLOR_BASE;
        end
        state_d = lgrb_pkg::ST_CHK;
      end
      lgrb_pkg::ST_CHK: begin
        if (neg_q) begin
          emit   = 1'b1;
          emit_h = '0;
        end else if (num_q >= NUM_W'(hrange_q)) begin
          emit   = 1'b1;
          emit_h = HGT_W'(GRAPH_HEIGHT);
        end else begin
          div_start = 1'b1;
          state_d   = lgrb_pkg::ST_DIV;
        end
      end
      lgrb_pkg::ST_DIV: begin
        if (div_done) begin
          emit   = 1'b1;
          emit_h = div_quo;
        end
      end
      default: begin
        state_d = lgrb_pkg::ST_IDLE;
      end
    endcase
    if (emit) begin
      if (idx_last) begin
        state_d = lgrb_pkg::ST_IDLE;
      end else begin
        idx_d   = idx_q + PTR_W'(1);
        state_d = lgrb_pkg::ST_RD;
      end
    end
  end

  always_comb begin
    out_valid_d = emit;
    column_d    = column_q;
    height_d    = height_q;
    pcolor_d    = pcolor_q;
    last_d      = last_q;
    if (emit) begin
      column_d = COL_W'(GRAPH_WIDTH - 1) - idx_q;
      height_d = emit_h;
      pcolor_d = color_q;
      last_d   = idx_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lgrb_pkg::ST_IDLE;
      graph_min_q <= lgrb_pkg::GRAPH_MIN_RST;
      graph_max_q <= lgrb_pkg::GRAPH_MAX_RST;
      idx_q       <= '0;
      drops_q     <= '0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      graph_min_q <= graph_min_d;
      graph_max_q <= graph_max_d;
      idx_q       <= idx_d;
      drops_q     <= drops_d;
      out_valid_q <= out_valid_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ping_q   <= ping_d;
    supp_q   <= supp_d;
    lo_q     <= lo_d;
    range_q  <= range_d;
    hrange_q <= hrange_d;
    neg_q    <= neg_d;
    num_q    <= num_d;
    color_q  <= color_d;
    column_q <= column_d;
    height_q <= height_d;
    pcolor_q <= pcolor_d;
  end

  lgrb_ring #(
    .GRAPH_WIDTH (GRAPH_WIDTH),
    .PTR_W       (PTR_W),
    .CNT_W       (CNT_W)
  ) u_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ring_ctl),
    .push_data_i (push_data),
    .rd_idx_i    (idx_q),
    .rd_data_o   (rd_data),
    .fill_o      (fill)
  );

  lgrb_div #(
    .NUM_W (NUM_W),
    .DEN_W (LIM_W),
    .QUO_W (HGT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_q),
    .den_i   (range_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign out_valid_o     = out_valid_q;
  assign column_o        = column_q;
  assign bar_height_o    = height_q;
  assign palette_color_o = pcolor_q;
  assign last_o          = last_q;

  // the final beat of a draw leaves the block idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> !busy)
    else $error("block still busy on final beat");

  // any other beat comes while the draw is still running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> state_q == lgrb_pkg::ST_RD)
    else $error("draw stopped before final beat");

  // divider only finishes inside the divide step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == lgrb_pkg::ST_DIV)
    else $error("divider result outside divide step");

  // bar height never exceeds the graph height
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> bar_height_o <= HGT_W'(GRAPH_HEIGHT))
    else $error("bar height out of range");

  // ring is never written during a draw
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_ctl.push |-> state_q == lgrb_pkg::ST_ADD)
    else $error("ring push outside add op");

endmodule
